FILE: src/dpod_pkg.sv
// Package for the date period overlap block: field widths, date and command
// types, and the month table used by the datapath.
// No dependencies.
package dpod_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DATE_W  = YEAR_W + MONTH_W + DAY_W;
    localparam int IN_W    = ((4 * DATE_W + 7) / 8) * 8;
    localparam int DAYS_W  = 23;
    localparam int OUT_W   = ((DAYS_W + 1 + 7) / 8) * 8;
    localparam int SER_W   = 22;
    localparam int CUM_W   = 9;

    localparam logic [YEAR_W-1:0]  MAX_YEAR = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] MARCH    = MONTH_W'(3);

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 2**YEAR_W
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
    localparam int PROD_W      = YEAR_W + RECIP_W;
    localparam int C4_W        = YEAR_W - 2;
    localparam int C100_W      = 7;
    localparam int C400_W      = 5;

    // Packed year-month-day, so a plain compare gives calendar order.
    typedef struct packed {
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        logic [DAY_W-1:0]   d;
    } date_t;

    typedef struct packed {
        logic load;
        logic order;
        logic step_a;
        logic step_b;
        logic step_c;
        logic sel_st;
        logic calc;
        logic load_out;
    } cmd_t;

    // Days before month m in a common year; months past December count all twelve.
    function automatic logic [CUM_W-1:0] month_cum(input logic [MONTH_W-1:0] m);
        logic [CUM_W-1:0] r;
        begin
            case (m)
                4'd2:    r = CUM_W'(31);
                4'd3:    r = CUM_W'(59);
                4'd4:    r = CUM_W'(90);
                4'd5:    r = CUM_W'(120);
                4'd6:    r = CUM_W'(151);
                4'd7:    r = CUM_W'(181);
                4'd8:    r = CUM_W'(212);
                4'd9:    r = CUM_W'(243);
                4'd10:   r = CUM_W'(273);
                4'd11:   r = CUM_W'(304);
                4'd12:   r = CUM_W'(334);
                4'd13, 4'd14, 4'd15: r = CUM_W'(365);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    function automatic date_t clamp_date(input logic [YEAR_W-1:0] y,
                                         input logic [MONTH_W-1:0] m,
                                         input logic [DAY_W-1:0] d);
        date_t r;
        begin
            r.y = (y > MAX_YEAR) ? MAX_YEAR : y;
            r.m = m;
            r.d = d;
            return r;
        end
    endfunction

endpackage

FILE: src/date_period_overlap_days.sv
// Date period overlap block: counts the days shared by two Gregorian periods.
// Top level; instantiates dpod_ctrl and dpod_datapath, uses dpod_pkg.
//
// Usage:
//   s_* channel: one transfer carries both periods (start and end dates of
//   each). The block takes one item at a time; s_tready is high only while
//   the sequencer is idle.
//   m_* channel: one result per item, the signed overlap day count and the
//   overlap flag. The count is zero when the periods do not overlap.
//   cfg_wen/cfg_wdata: writes include_end_day; write it while idle.
//   Each item passes the ordering step, two three-stage passes of the
//   shared day-number unit and the final count before its result is
//   presented; a new item is taken only once the sequencer is idle again.
//   A finished result sits in the output register; the next item is taken
//   while it waits. If the receiver still stalls when the following count
//   is ready, the sequencer holds that count until the register frees.
//   Reset clears the sequencer, the output valid and include_end_day.
module date_period_overlap_days (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // first_start_year, first_start_month, first_start_day, first_end_year,
    // first_end_month, first_end_day, second_start_year, second_start_month,
    // second_start_day, second_end_year, second_end_month, second_end_day
    input  logic [dpod_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // overlap_days, overlaps
    output logic [dpod_pkg::OUT_W-1:0] m_tdata,
    input  logic                       cfg_wen,
    input  logic                       cfg_wdata
);
    import dpod_pkg::*;

    cmd_t cmd;

    dpod_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dpod_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: src/dpod_ctrl.sv
// Sequencer for the date period overlap block: steps the datapath through
// ordering, two day-number passes and the final count. Uses dpod_pkg.
module dpod_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output dpod_pkg::cmd_t cmd
);
    import dpod_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ORDER,
        ST_EN_A,
        ST_EN_B,
        ST_EN_C,
        ST_ST_A,
        ST_ST_B,
        ST_ST_C,
        ST_CALC,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ORDER;
                end
            end
            ST_ORDER:
            begin
                cmd.order  = 1'b1;
                state_next = ST_EN_A;
            end
            ST_EN_A:
            begin
                cmd.step_a = 1'b1;
                state_next = ST_EN_B;
            end
            ST_EN_B:
            begin
                cmd.step_b = 1'b1;
                state_next = ST_EN_C;
            end
            ST_EN_C:
            begin
                cmd.step_c = 1'b1;
                state_next = ST_ST_A;
            end
            ST_ST_A:
            begin
                cmd.step_a = 1'b1;
                cmd.sel_st = 1'b1;
                state_next = ST_ST_B;
            end
            ST_ST_B:
            begin
                cmd.step_b = 1'b1;
                cmd.sel_st = 1'b1;
                state_next = ST_ST_C;
            end
            ST_ST_C:
            begin
                cmd.step_c = 1'b1;
                cmd.sel_st = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result register loaded while a result is pending");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_ORDER))
        else $error("accepted transfer did not start the sequence");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !m_tvalid_reg) |=> (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("finished count not presented");

endmodule

FILE: src/dpod_datapath.sv
// Datapath for the date period overlap block: date registers, ordering,
// a three-stage day-number unit shared by both dates, and the result register.
// Uses dpod_pkg.
module dpod_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dpod_pkg::cmd_t            cmd,
    input  logic [dpod_pkg::IN_W-1:0] s_tdata,
    input  logic                      cfg_wen,
    input  logic                      cfg_wdata,
    output logic [dpod_pkg::OUT_W-1:0] m_tdata
);
    import dpod_pkg::*;

    logic include_end_day_reg;

    date_t s1_reg, e1_reg, s2_reg, e2_reg;
    date_t st_reg, en_reg;
    logic  neg_reg, ov_reg;

    // day-number unit stage registers
    logic [YEAR_W-1:0]  y_a_reg;
    logic [MONTH_W-1:0] m_a_reg, m_b_reg;
    logic [DAY_W-1:0]   d_a_reg, d_b_reg;
    logic [SER_W-1:0]   y365_a_reg;
    logic [PROD_W-1:0]  p100_a_reg, p400_a_reg;
    logic [SER_W-1:0]   part_b_reg;
    logic               leap_b_reg;
    logic [SER_W-1:0]   sen_reg, sst_reg;

    logic [DAYS_W-1:0]  days_reg;
    logic [DAYS_W-1:0]  out_days_reg;
    logic               out_ov_reg;

    date_t              st_pick, en_pick, cur;
    logic               ov_next;
    logic [YEAR_W-1:0]  y_99, y_399, y_3;
    logic [C4_W-1:0]    c4;
    logic [C100_W-1:0]  c100;
    logic [C400_W-1:0]  c400;
    logic               div100, div400;
    logic [SER_W-1:0]   ser;
    logic signed [DAYS_W:0] diff, signed_diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            include_end_day_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            include_end_day_reg <= cfg_wdata;
        end
    end

    // ordering: later start, earlier end, swapped when reversed
    always_comb
    begin
        ov_next = !((e2_reg < s1_reg) || (e1_reg < s2_reg));
        st_pick = (s2_reg < s1_reg) ? s1_reg : s2_reg;
        en_pick = (e1_reg < e2_reg) ? e1_reg : e2_reg;
    end

    // stage A: reciprocal products and the year term
    assign cur   = cmd.sel_st ? st_reg : en_reg;
    assign y_99  = cur.y + YEAR_W'(99);
    assign y_399 = cur.y + YEAR_W'(399);

    // stage B: century corrections and the leap flag
    assign y_3    = y_a_reg + YEAR_W'(3);
    assign c4     = y_3[YEAR_W-1:2];
    assign c100   = p100_a_reg[RECIP_SHIFT +: C100_W];
    assign c400   = p400_a_reg[RECIP_SHIFT + 2 +: C400_W];
    assign div100 = ((YEAR_W'(c100) * YEAR_W'(100)) == y_a_reg);
    assign div400 = ((YEAR_W'(c400) * YEAR_W'(400)) == y_a_reg);

    // stage C: months and day
    assign ser = part_b_reg + SER_W'(month_cum(m_b_reg))
               + SER_W'(leap_b_reg && (m_b_reg >= MARCH)) + SER_W'(d_b_reg);

    always_comb
    begin
        diff = $signed({2'b00, sen_reg}) - $signed({2'b00, sst_reg})
             + $signed({{DAYS_W{1'b0}}, include_end_day_reg});
        signed_diff = neg_reg ? -diff : diff;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s1_reg <= clamp_date(s_tdata[13:0],  s_tdata[17:14], s_tdata[22:18]);
            e1_reg <= clamp_date(s_tdata[36:23], s_tdata[40:37], s_tdata[45:41]);
            s2_reg <= clamp_date(s_tdata[59:46], s_tdata[63:60], s_tdata[68:64]);
            e2_reg <= clamp_date(s_tdata[82:69], s_tdata[86:83], s_tdata[91:87]);
        end
        if (cmd.order)
        begin
            ov_reg  <= ov_next;
            neg_reg <= (en_pick < st_pick);
            st_reg  <= (en_pick < st_pick) ? en_pick : st_pick;
            en_reg  <= (en_pick < st_pick) ? st_pick : en_pick;
        end
        if (cmd.step_a)
        begin
            y_a_reg    <= cur.y;
            m_a_reg    <= cur.m;
            d_a_reg    <= cur.d;
            y365_a_reg <= SER_W'(cur.y) * SER_W'(365);
            p100_a_reg <= PROD_W'(y_99) * PROD_W'(RECIP_100);
            p400_a_reg <= PROD_W'(y_399) * PROD_W'(RECIP_100);
        end
        if (cmd.step_b)
        begin
            part_b_reg <= y365_a_reg + SER_W'(c4) - SER_W'(c100) + SER_W'(c400);
            leap_b_reg <= div400 || ((y_a_reg[1:0] == 2'b00) && !div100);
            m_b_reg    <= m_a_reg;
            d_b_reg    <= d_a_reg;
        end
        if (cmd.step_c)
        begin
            if (cmd.sel_st)
            begin
                sst_reg <= ser;
            end
            else
            begin
                sen_reg <= ser;
            end
        end
        if (cmd.calc)
        begin
            days_reg <= ov_reg ? signed_diff[DAYS_W-1:0] : '0;
        end
        if (cmd.load_out)
        begin
            out_days_reg <= days_reg;
            out_ov_reg   <= ov_reg;
        end
    end

    assign m_tdata = OUT_W'({out_ov_reg, out_days_reg});

    a_zero_when_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && !ov_reg) |=> (out_days_reg == '0))
        else $error("nonzero count for periods that do not overlap");

endmodule
